[sv/nct_pkg.sv]
// ----------------------------------------------------------------------------
// nct_pkg
// Shared types and constants of the nested comment tokenizer: byte classes,
// token kinds, status codes and the item format between front and back.
// ----------------------------------------------------------------------------
package nct_pkg;

   // Byte values with a meaning of their own
   localparam logic [7:0] CHR_OPEN  = 8'h7B;   // '{'
   localparam logic [7:0] CHR_CLOSE = 8'h7D;   // '}'
   localparam logic [7:0] CHR_BANG  = 8'h21;   // '!'
   localparam logic [7:0] CHR_SPACE = 8'h20;   // ' '
   localparam logic [7:0] CHR_EQ    = 8'h3D;   // '='
   localparam logic [7:0] CHR_LF    = 8'h0A;   // '\n'
   localparam logic [7:0] CHR_CR    = 8'h0D;   // '\r'

   // Defaults for the top-level and queue parameters
   localparam int MAX_COMMENT_DEPTH_DEF = 255;
   localparam int QUEUE_DEPTH_DEF       = 2;

   // Line counter saturates here
   localparam logic [15:0] LINE_MAX = 16'hFFFF;

   // Byte classes produced by the front end
   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_SPACE,
      CLS_CR,
      CLS_LF,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_BANG,
      CLS_EQ
   } char_class_type;

   // Token kinds on the result channel
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_WORD = 2'd1;
   localparam logic [1:0] KIND_SYM  = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_STRAY  = 2'd1;
   localparam logic [1:0] ST_UNTERM = 2'd2;
   localparam logic [1:0] ST_DEEP   = 2'd3;

   // Classified item carried from front to back
   typedef struct packed {
      logic [7:0]     chr;
      char_class_type cls;
      logic           eoi;
   } nct_item_type;

endpackage

[sv/nct_front.sv]
// ----------------------------------------------------------------------------
// nct_front
// Front end: takes a byte or end mark from the request side, classifies the
// byte and hands the classified item to the queue.
// ----------------------------------------------------------------------------
module nct_front (
   input  logic                 req_push,
   input  logic [7:0]           req_char_code,
   input  logic                 req_end_of_input,
   input  logic                 q_full,
   output logic                 q_push,
   output nct_pkg::nct_item_type q_item
);
   import nct_pkg::*;

   char_class_type cls;

   // Classify the byte
   always_comb begin
      unique case (req_char_code)
         CHR_SPACE: cls = CLS_SPACE;
         CHR_CR:    cls = CLS_CR;
         CHR_LF:    cls = CLS_LF;
         CHR_OPEN:  cls = CLS_OPEN;
         CHR_CLOSE: cls = CLS_CLOSE;
         CHR_BANG:  cls = CLS_BANG;
         CHR_EQ:    cls = CLS_EQ;
         default:   cls = CLS_OTHER;
      endcase
   end

   // Forward the transfer to the queue; the end mark clears the byte
   assign q_push     = req_push && !q_full;
   assign q_item.chr = req_end_of_input ? 8'd0 : req_char_code;
   assign q_item.cls = req_end_of_input ? CLS_OTHER : cls;
   assign q_item.eoi = req_end_of_input;

endmodule

[sv/nct_queue.sv]
// ----------------------------------------------------------------------------
// nct_queue
// Short queue of classified items between front and back end; push and pop
// may happen in the same cycle.
// ----------------------------------------------------------------------------
module nct_queue #(
   parameter int DEPTH = nct_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  nct_pkg::nct_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output nct_pkg::nct_item_type pop_item,
   output logic                  empty
);
   import nct_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   nct_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[sv/nct_back.sv]
// ----------------------------------------------------------------------------
// nct_back
// Back end: runs the scan mode machine, comment depth, line counter and
// sticky status on each classified item and holds the result register.
// ----------------------------------------------------------------------------
module nct_back #(
   parameter int MAX_COMMENT_DEPTH = nct_pkg::MAX_COMMENT_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nct_pkg::nct_item_type q_item,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_token_byte,
   output logic [1:0]            rsp_token_kind,
   output logic                  rsp_starts_token,
   output logic [15:0]           rsp_line_count,
   output logic [1:0]            rsp_status,
   output logic                  rsp_stream_end
);
   import nct_pkg::*;

   localparam int DW = $clog2(MAX_COMMENT_DEPTH + 1);
   localparam logic [DW-1:0] DEPTH_LIMIT = DW'(MAX_COMMENT_DEPTH);
   localparam logic [DW-1:0] DEPTH_ONE   = DW'(1);

   typedef enum logic [2:0] {
      MODE_GAP,
      MODE_WORD,
      MODE_SYM,
      MODE_BRACE,
      MODE_LINE
   } mode_type;

   mode_type      mode_ff, mode_in;
   logic [DW-1:0] depth_ff, depth_in, depth_dec;
   logic [15:0]   line_ff, line_in;
   logic [1:0]    err_ff, err_in;
   logic          out_valid_ff;
   logic [1:0]    kind_in;
   logic          starts_in;
   logic          take;

   // Take a new item when the result register is free or being drained
   assign take      = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop     = take;
   assign rsp_empty = !out_valid_ff;
   assign depth_dec = (depth_ff != '0) ? depth_ff - 1'b1 : depth_ff;

   // Next state of the scanner
   always_comb begin
      mode_in   = mode_ff;
      depth_in  = depth_ff;
      line_in   = line_ff;
      err_in    = err_ff;
      kind_in   = KIND_NONE;
      starts_in = 1'b0;
      if (q_item.eoi) begin
         if (mode_ff == MODE_BRACE && err_ff == ST_OK) begin
            err_in = ST_UNTERM;
         end
      end else begin
         if (q_item.cls == CLS_LF && line_ff != LINE_MAX) begin
            line_in = line_ff + 1'b1;
         end
         unique case (mode_ff)
            MODE_BRACE: begin
               if (q_item.cls == CLS_OPEN) begin
                  if (depth_ff >= DEPTH_LIMIT) begin
                     if (err_ff == ST_OK) err_in = ST_DEEP;
                  end else begin
                     depth_in = depth_ff + 1'b1;
                  end
               end else if (q_item.cls == CLS_CLOSE) begin
                  depth_in = depth_dec;
                  if (depth_dec == '0) mode_in = MODE_GAP;
               end
            end
            MODE_LINE: begin
               if (q_item.cls == CLS_LF || q_item.cls == CLS_CR) mode_in = MODE_GAP;
            end
            default: begin
               unique case (q_item.cls)
                  CLS_SPACE, CLS_CR, CLS_LF: mode_in = MODE_GAP;
                  CLS_OPEN: begin
                     mode_in  = MODE_BRACE;
                     depth_in = DEPTH_ONE;
                  end
                  CLS_CLOSE: begin
                     if (err_ff == ST_OK) err_in = ST_STRAY;
                     mode_in = MODE_GAP;
                  end
                  CLS_BANG: mode_in = MODE_LINE;
                  CLS_EQ: begin
                     kind_in   = KIND_SYM;
                     starts_in = (mode_ff != MODE_SYM);
                     mode_in   = MODE_SYM;
                  end
                  default: begin
                     kind_in   = KIND_WORD;
                     starts_in = (mode_ff != MODE_WORD);
                     mode_in   = MODE_WORD;
                  end
               endcase
            end
         endcase
      end
   end

   // Hold state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_GAP;
         depth_ff     <= '0;
         line_ff      <= 16'd1;
         err_ff       <= ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            if (q_item.eoi) begin
               mode_ff  <= MODE_GAP;
               depth_ff <= '0;
               line_ff  <= 16'd1;
               err_ff   <= ST_OK;
            end else begin
               mode_ff  <= mode_in;
               depth_ff <= depth_in;
               line_ff  <= line_in;
               err_ff   <= err_in;
            end
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (take) begin
         rsp_token_byte   <= q_item.chr;
         rsp_token_kind   <= kind_in;
         rsp_starts_token <= starts_in;
         rsp_line_count   <= line_in;
         rsp_status       <= err_in;
         rsp_stream_end   <= q_item.eoi;
      end
   end

endmodule

[sv/nested_comment_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// nested_comment_tokenizer_unit
// Byte-serial lexer with nested brace comments, line comments and line count.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue input: drive req_char_code / req_end_of_input
//   with req_push; a transfer happens on an edge with req_push high and
//   req_full low. An end mark returns the scanner to its start state.
//   Result side is a queue output: while rsp_empty is low the oldest result
//   sits on the rsp_ ports; a transfer happens on an edge with rsp_pop high.
//   Every request gives exactly one result, in order.
// Timing:
//   A taken request passes through the queue and then the result register
//   before its result is offered. The unit takes one byte per cycle when
//   results are popped each cycle.
//   A two-entry queue sits between classifier and scanner, so a stalled
//   result side fills the queue and then raises req_full; nothing is lost.
// Reset:
//   Synchronous reset empties the queue and result register, sets the line
//   count to one, clears status and comment depth.
// ----------------------------------------------------------------------------
module nested_comment_tokenizer_unit #(
   parameter int MAX_COMMENT_DEPTH = nct_pkg::MAX_COMMENT_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_input,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_token_byte,
   output logic [1:0]  rsp_token_kind,
   output logic        rsp_starts_token,
   output logic [15:0] rsp_line_count,
   output logic [1:0]  rsp_status,
   output logic        rsp_stream_end
);
   import nct_pkg::*;

   nct_item_type front_item;
   nct_item_type back_item;
   logic         q_push, q_full, q_pop, q_empty;

   assign req_full = q_full;

   // Classify incoming bytes
   nct_front u_front (
      .req_push         (req_push),
      .req_char_code    (req_char_code),
      .req_end_of_input (req_end_of_input),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_item           (front_item)
   );

   // Decouple classifier and scanner
   nct_queue #(
      .DEPTH (QUEUE_DEPTH_DEF)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (back_item),
      .empty     (q_empty)
   );

   // Scan and produce results
   nct_back #(
      .MAX_COMMENT_DEPTH (MAX_COMMENT_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_item           (back_item),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_token_byte   (rsp_token_byte),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_starts_token (rsp_starts_token),
      .rsp_line_count   (rsp_line_count),
      .rsp_status       (rsp_status),
      .rsp_stream_end   (rsp_stream_end)
   );

endmodule

[sv/nct_checker.sv]
// ----------------------------------------------------------------------------
// nct_checker
// Port-level checks of the tokenizer results, bound to the top level.
// ----------------------------------------------------------------------------
module nct_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic [7:0]  rsp_token_byte,
   input logic [1:0]  rsp_token_kind,
   input logic        rsp_starts_token,
   input logic [15:0] rsp_line_count,
   input logic        rsp_stream_end
);
   import nct_pkg::*;

   // Reset leaves no result waiting
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result offered right after reset");

   // The end-of-input result carries no byte and no token
   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_stream_end) |->
         (rsp_token_byte == 8'd0 && rsp_token_kind == KIND_NONE && !rsp_starts_token))
      else $error("end-of-input result carries token data");

   // Only word or symbol bytes may start a token
   a_start_kind: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_token_kind == KIND_NONE) |-> !rsp_starts_token)
      else $error("token start on a skipped byte");

   // Kind code three never appears
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_token_kind != 2'd3))
      else $error("undefined token kind");

   // Line count never drops to zero
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_line_count != 16'd0))
      else $error("line count is zero");

endmodule

bind nested_comment_tokenizer_unit nct_checker u_nct_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_empty        (rsp_empty),
   .rsp_token_byte   (rsp_token_byte),
   .rsp_token_kind   (rsp_token_kind),
   .rsp_starts_token (rsp_starts_token),
   .rsp_line_count   (rsp_line_count),
   .rsp_stream_end   (rsp_stream_end)
);
